### src/atan2mp_pkg.sv
// shared types and constants for the atan2 polynomial pipeline
`timescale 1ns / 1ps
`default_nettype none
package atan2mp_pkg;
	localparam int ACC_FRAC   = 17;
	localparam int RATIO_FRAC = 16;
	localparam int RATIO_W    = RATIO_FRAC + 1;
	localparam int ACC_W      = 20;
	localparam int PROD_W     = 40;
	localparam int HORNER_N   = 5;
	localparam int ANGLE_W    = 16;

	localparam logic signed [ACC_W-1:0] K1  = 20'sd131069;
	localparam logic signed [ACC_W-1:0] K3  = -20'sd43598;
	localparam logic signed [ACC_W-1:0] K5  = 20'sd25368;
	localparam logic signed [ACC_W-1:0] K7  = -20'sd15261;
	localparam logic signed [ACC_W-1:0] K9  = 20'sd6901;
	localparam logic signed [ACC_W-1:0] K11 = -20'sd1536;
	localparam logic signed [ACC_W-1:0] HALF_PI_Q17 = 20'sd205887;
	localparam logic signed [ACC_W-1:0] PI_Q17      = 20'sd411775;

	typedef struct packed {
		logic swap;
		logic xzero;
		logic yzero;
		logic flip;
		logic xneg;
		logic yneg;
	} atan2mp_meta_t;

	// horner coefficients after the leading one, highest order first
	function automatic logic signed [ACC_W-1:0] horner_coef(input logic [2:0] idx);
		logic signed [ACC_W-1:0] k;
		case (idx)
			3'd0: k = K9;
			3'd1: k = K7;
			3'd2: k = K5;
			3'd3: k = K3;
			3'd4: k = K1;
			default: k = '0;
		endcase
		return k;
	endfunction
endpackage
`default_nettype wire

### src/atan2mp_div.sv
// pipelined restoring divider producing the q1.16 magnitude ratio
`timescale 1ns / 1ps
`default_nettype none
module atan2mp_div #(
	parameter int IN_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [IN_WIDTH-1:0]         num,
	input  wire logic [IN_WIDTH-1:0]         den,
	input  wire atan2mp_pkg::atan2mp_meta_t  in_meta,
	output logic                             out_valid,
	output logic [atan2mp_pkg::RATIO_W-1:0]  quot,
	output atan2mp_pkg::atan2mp_meta_t       out_meta
);
	import atan2mp_pkg::*;

	localparam int STEPS = RATIO_W;

	logic                valid_s [0:STEPS];
	logic [IN_WIDTH:0]   rem_s   [0:STEPS];
	logic [IN_WIDTH-1:0] den_s   [0:STEPS];
	logic [RATIO_W-1:0]  q_s     [0:STEPS];
	atan2mp_meta_t       meta_s  [0:STEPS];

	always_comb begin
		valid_s[0] = in_valid;
		rem_s[0]   = {1'b0, num};
		den_s[0]   = den;
		q_s[0]     = '0;
		meta_s[0]  = in_meta;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [IN_WIDTH:0] trial;
		logic              ge;
		always_comb begin
			// first step tests the unshifted numerator for the integer bit
			trial = (i == 0) ? rem_s[i] : {rem_s[i][IN_WIDTH-1:0], 1'b0};
			ge    = trial >= {1'b0, den_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? trial - {1'b0, den_s[i]} : trial;
				den_s[i+1]  <= den_s[i];
				q_s[i+1]    <= {q_s[i][RATIO_W-2:0], ge};
				meta_s[i+1] <= meta_s[i];
			end
		end
	end

	assign out_valid = valid_s[STEPS];
	assign quot      = q_s[STEPS];
	assign out_meta  = meta_s[STEPS];
endmodule
`default_nettype wire

### src/atan2_minimax_polynomial.sv
// top level: four-quadrant arctangent pipeline with stream ports
`timescale 1ns / 1ps
`default_nettype none
// Computes atan2(y, x) in radians as a signed 16-bit angle with ANGLE_FRAC_BITS
// fractional bits (Q3.13 by default). One word is accepted every clock while no
// result waits at the output; each word passes through the input register, the 17-step
// ratio divider (one quotient bit per stage), the ratio square, five Horner
// multiply-add stages, the final ratio multiply, and the quadrant fixup feeding
// the output register. The whole pipeline halts while a result waits.
module atan2_minimax_polynomial #(
	parameter int IN_WIDTH        = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [((2*IN_WIDTH+7)/8)*8-1:0]       s_tdata,  // y_value, x_value
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [atan2mp_pkg::ANGLE_W-1:0]            m_tdata   // angle
);
	import atan2mp_pkg::*;

	localparam int SHR = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int OUT_CALC_W = 48;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input split and magnitude prep
	logic signed [IN_WIDTH-1:0] y_in, x_in;
	logic [IN_WIDTH-1:0]        ay, ax;
	atan2mp_meta_t              meta_in;
	always_comb begin
		y_in = s_tdata[IN_WIDTH-1:0];
		x_in = s_tdata[2*IN_WIDTH-1:IN_WIDTH];
		ay   = y_in[IN_WIDTH-1] ? IN_WIDTH'(-y_in) : IN_WIDTH'(y_in);
		ax   = x_in[IN_WIDTH-1] ? IN_WIDTH'(-x_in) : IN_WIDTH'(x_in);
		meta_in.swap  = ay > ax;
		meta_in.xzero = x_in == '0;
		meta_in.yzero = y_in == '0;
		meta_in.flip  = (y_in != '0) && (y_in[IN_WIDTH-1] != x_in[IN_WIDTH-1]);
		meta_in.xneg  = x_in[IN_WIDTH-1];
		meta_in.yneg  = y_in[IN_WIDTH-1];
	end

	logic                valid_s1;
	logic [IN_WIDTH-1:0] num_s1, den_s1;
	atan2mp_meta_t       meta_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= meta_in.swap ? ax : ay;
			den_s1  <= meta_in.swap ? ay : ax;
			meta_s1 <= meta_in;
		end
	end

	logic               div_valid;
	logic [RATIO_W-1:0] div_q;
	atan2mp_meta_t      div_meta;
	atan2mp_div #(.IN_WIDTH(IN_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.num      (num_s1),
		.den      (den_s1),
		.in_meta  (meta_s1),
		.out_valid(div_valid),
		.quot     (div_q),
		.out_meta (div_meta)
	);

	// ratio square
	logic [2*RATIO_W-1:0] rsq;
	assign rsq = div_q * div_q + (2*RATIO_W)'(1 << (RATIO_FRAC-1));

	logic                       valid_h [0:HORNER_N];
	logic signed [ACC_W-1:0]    acc_h   [0:HORNER_N];
	logic [RATIO_W-1:0]         r_h     [0:HORNER_N];
	logic [RATIO_W-1:0]         r2_h    [0:HORNER_N];
	atan2mp_meta_t              meta_h  [0:HORNER_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_h[0] <= 1'b0;
		end else if (en) begin
			valid_h[0] <= div_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			acc_h[0]  <= K11;
			r_h[0]    <= div_q;
			r2_h[0]   <= rsq[RATIO_FRAC +: RATIO_W];
			meta_h[0] <= div_meta;
		end
	end

	for (genvar k = 0; k < HORNER_N; k++) begin : g_horner
		logic signed [PROD_W-1:0] prod;
		assign prod = PROD_W'(acc_h[k]) * $signed({1'b0, r2_h[k]})
			+ PROD_W'(1 << (RATIO_FRAC-1));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_h[k+1] <= 1'b0;
			end else if (en) begin
				valid_h[k+1] <= valid_h[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				acc_h[k+1]  <= horner_coef(3'(k)) + ACC_W'(prod >>> RATIO_FRAC);
				r_h[k+1]    <= r_h[k];
				r2_h[k+1]   <= r2_h[k];
				meta_h[k+1] <= meta_h[k];
			end
		end
	end

	// final multiply by the ratio
	logic signed [PROD_W-1:0] pfin;
	assign pfin = PROD_W'(acc_h[HORNER_N]) * $signed({1'b0, r_h[HORNER_N]})
		+ PROD_W'(1 << (RATIO_FRAC-1));

	logic                    valid_p;
	logic signed [ACC_W-1:0] poly_p;
	atan2mp_meta_t           meta_p;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_p <= 1'b0;
		end else if (en) begin
			valid_p <= valid_h[HORNER_N];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			poly_p <= ACC_W'(pfin >>> RATIO_FRAC);
			meta_p <= meta_h[HORNER_N];
		end
	end

	// quadrant fixup and output scaling
	logic signed [ACC_W+1:0]      res;
	logic signed [OUT_CALC_W-1:0] scaled;
	logic [ANGLE_W-1:0]           angle_next;
	always_comb begin
		res = meta_p.swap ? (ACC_W+2)'(HALF_PI_Q17) - (ACC_W+2)'(poly_p)
			: (ACC_W+2)'(poly_p);
		if (meta_p.flip) begin
			res = -res;
		end
		if (meta_p.xneg) begin
			res = meta_p.yneg ? res - (ACC_W+2)'(PI_Q17) : res + (ACC_W+2)'(PI_Q17);
		end
		if (meta_p.xzero) begin
			if (meta_p.yzero) begin
				res = '0;
			end else if (meta_p.yneg) begin
				res = -(ACC_W+2)'(HALF_PI_Q17);
			end else begin
				res = (ACC_W+2)'(HALF_PI_Q17);
			end
		end
	end

	if (SHR > 0) begin : g_shr
		assign scaled = (OUT_CALC_W'(res) + OUT_CALC_W'(1 << (SHR-1))) >>> SHR;
	end else begin : g_shl
		assign scaled = OUT_CALC_W'(res) <<< (-SHR);
	end

	always_comb begin
		if (scaled > OUT_CALC_W'(32767)) begin
			angle_next = 16'h7fff;
		end else if (scaled < -OUT_CALC_W'(32768)) begin
			angle_next = 16'h8000;
		end else begin
			angle_next = scaled[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= valid_p;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= angle_next;
		end
	end
endmodule
`default_nettype wire

### verif/tb_atan2_minimax_polynomial.sv
// self-checking testbench for the atan2 polynomial pipeline
`timescale 1ns / 1ps
module tb_atan2_minimax_polynomial;
	import atan2mp_pkg::*;

	localparam int IN_W = 16;
	localparam int ANGLE_FB = 13;
	localparam int LATENCY = 27;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;   // y_value, x_value
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;   // angle

	logic [31:0] pending_words[$];
	logic [15:0] expected_angles[$];
	int fail_count;
	int send_gap;
	int recv_gap;
	bit hold_sender;
	bit stim_done;

	atan2_minimax_polynomial #(.IN_WIDTH(IN_W), .ANGLE_FRAC_BITS(ANGLE_FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint rnd_shift(longint v, int n);
		longint t;
		t = v + (64'sd1 <<< (n - 1));
		return t >>> n;
	endfunction

	function automatic logic [15:0] predict_angle(logic signed [15:0] y, logic signed [15:0] x);
		longint yy, xx, ay, ax, res, num, den, r, r2, acc, v;
		bit swap;
		yy = y;
		xx = x;
		ay = yy < 0 ? -yy : yy;
		ax = xx < 0 ? -xx : xx;
		if (xx == 0) begin
			res = yy > 0 ? longint'(HALF_PI_Q17) : (yy < 0 ? -longint'(HALF_PI_Q17) : 0);
		end else begin
			swap = ay > ax;
			num = swap ? ax : ay;
			den = swap ? ay : ax;
			r = (num <<< RATIO_FRAC) / den;
			r2 = rnd_shift(r * r, RATIO_FRAC);
			acc = K11;
			acc = K9 + rnd_shift(acc * r2, RATIO_FRAC);
			acc = K7 + rnd_shift(acc * r2, RATIO_FRAC);
			acc = K5 + rnd_shift(acc * r2, RATIO_FRAC);
			acc = K3 + rnd_shift(acc * r2, RATIO_FRAC);
			acc = K1 + rnd_shift(acc * r2, RATIO_FRAC);
			res = rnd_shift(acc * r, RATIO_FRAC);
			if (swap)
				res = longint'(HALF_PI_Q17) - res;
			if (yy != 0 && ((yy < 0) != (xx < 0)))
				res = -res;
			if (xx < 0)
				res = yy >= 0 ? res + longint'(PI_Q17) : res - longint'(PI_Q17);
		end
		v = rnd_shift(res, ACC_FRAC - ANGLE_FB);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'(int'($urandom_range(0, 8)) - 4);
			1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			2: return 16'(int'($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: sends queued words, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_angles.push_back(predict_angle(s_tdata[15:0], s_tdata[31:16]));
				void'(pending_words.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				// hold the word
			end else if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_words.size() > (s_tvalid && s_tready ? 0 : 0) && !hold_sender) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_words[0];
				send_gap <= $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 3));
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: random back-pressure, compares each angle in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_angles.size() == 0) begin
					$error("angle: unexpected word, actual %0d", $signed(m_tdata));
					fail_count <= fail_count + 1;
				end else begin
					if (m_tdata !== expected_angles[0]) begin
						$error("angle: expected %0d actual %0d",
							$signed(expected_angles[0]), $signed(m_tdata));
						fail_count <= fail_count + 1;
					end
					void'(expected_angles.pop_front());
				end
			end
			if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready)
					recv_gap <= stim_done ? 0 : int'($urandom_range(0, 3));
			end
		end
	end

	initial begin
		logic [15:0] edge_vals[8];
		logic [15:0] ycomp, xcomp;
		int waited;
		edge_vals = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h8001, 16'h5555, 16'haaaa};
		fail_count = 0;
		hold_sender = 1'b0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: signs, zeros, equal magnitudes, most negative values
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				pending_words.push_back({edge_vals[j], edge_vals[i]});
		pending_words.push_back({16'h8000, 16'h8000});
		pending_words.push_back({16'h8000, 16'h7fff});
		// let the pipeline drain completely once
		wait (pending_words.size() == 0);
		@(posedge clk);
		hold_sender = 1'b1;
		wait (expected_angles.size() == 0);
		@(posedge clk);
		hold_sender = 1'b0;
		for (int n = 0; n < 1550; n++) begin
			ycomp = rand_comp();
			xcomp = rand_comp();
			if ($urandom_range(0, 9) == 0)
				xcomp = $urandom_range(0, 1) ? ycomp : -ycomp;
			pending_words.push_back({xcomp, ycomp});
		end
		wait (pending_words.size() == 0);
		stim_done = 1'b1;
		waited = 0;
		while (expected_angles.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && expected_angles.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end
endmodule
